// File: hdl/obue_pkg.sv
// ----------------------------------------------------------------------------
// Order book update engine package
// Shared item types, update and status codes, and default sizes.
// ----------------------------------------------------------------------------
package obue_pkg;

   // Default sizes for the top-level parameters.
   localparam int OBUE_SLOTS       = 4096;
   localparam int OBUE_EPOCH_BITS  = 16;
   localparam int OBUE_QUEUE_DEPTH = 4;

   // Update kinds as they arrive on the input item.
   localparam logic [2:0] KIND_ADD    = 3'd0;
   localparam logic [2:0] KIND_CANCEL = 3'd1;
   localparam logic [2:0] KIND_MODIFY = 3'd2;
   localparam logic [2:0] KIND_TRADE  = 3'd3;
   localparam logic [2:0] KIND_CLEAR  = 3'd4;

   // Result status codes.
   localparam logic [1:0] STATUS_SHORT  = 2'd0;
   localparam logic [1:0] STATUS_IN_SEQ = 2'd1;
   localparam logic [1:0] STATUS_GAP    = 2'd2;

   // One decoded market update.
   typedef struct packed {
      logic [2:0]  kind;
      logic        short_frame;
      logic [31:0] seq_number;
      logic [63:0] order_key;
      logic [15:0] instrument;
      logic [31:0] px;
      logic [31:0] qty;
      logic [63:0] stamp;
   } req_type;

   // One result item.
   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] gaps_seen;
      logic [31:0] packets_seen;
      logic        matched;
      logic        slot_active;
      logic [31:0] slot_price;
      logic [31:0] slot_quantity;
      logic        trade_seen;
      logic [15:0] epoch_now;
   } rsp_type;

   // A classified item waiting in the queue for the table stage.
   typedef struct packed {
      logic        short_frame;
      logic [2:0]  kind;
      logic [1:0]  status;
      logic [31:0] gaps_seen;
      logic [31:0] packets_seen;
      logic [63:0] order_key;
      logic [31:0] px;
      logic [31:0] qty;
   } work_type;

   // Queue fill status seen by both sides.
   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

// File: hdl/order_book_update_engine.sv
// ----------------------------------------------------------------------------
// Order book update engine
// Sequence checking and direct-mapped order table update for decoded
// market data items.
//
//   Channel   Ports                      Handshake
//   input     start, busy, req_item      taken when start is high, busy low
//   result    rsp_strobe, rsp_item       valid for one cycle, always taken
//
// An item is classified by the front end in the cycle it is accepted and
// queued. The table stage takes one item at a time: it reads the slot as
// the item leaves the queue, then updates and writes it back, and takes no
// new item until that result is out. With the queue empty, an accepted
// item passes through the queue entry, the table stage's work register and
// the result register. After reset the table is cleared one slot per cycle
// with busy held high; busy is also high while the queue is full. Instrument
// and timestamp are not stored: no result depends on them. SLOTS is to be a
// power of two, not checked here; the slot is the low bits of the order key.
// ----------------------------------------------------------------------------
module order_book_update_engine #(
   parameter int SLOTS       = obue_pkg::OBUE_SLOTS,
   parameter int EPOCH_BITS  = obue_pkg::OBUE_EPOCH_BITS,
   parameter int QUEUE_DEPTH = obue_pkg::OBUE_QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  obue_pkg::req_type req_item,
   output logic              rsp_strobe,
   output obue_pkg::rsp_type rsp_item
);

   logic                   accept;
   logic                   pop;
   logic                   clearing;
   obue_pkg::work_type     work_item;
   obue_pkg::work_type     head_item;
   obue_pkg::q_status_type q_status;

   // Accept while the table is ready and the queue has room.
   assign busy   = q_status.full || clearing;
   assign accept = start && !busy;

   obue_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req_item  (req_item),
      .work_item (work_item)
   );

   obue_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_item (work_item),
      .pop       (pop),
      .head_item (head_item),
      .q_status  (q_status)
   );

   obue_back #(
      .SLOTS      (SLOTS),
      .EPOCH_BITS (EPOCH_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_item  (head_item),
      .q_status   (q_status),
      .pop        (pop),
      .clearing   (clearing),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

endmodule

// File: hdl/obue_front.sv
// ----------------------------------------------------------------------------
// Order book update engine front end
// Checks sequence numbers, keeps the gap and packet counters and classifies
// each accepted item for the table stage.
// ----------------------------------------------------------------------------
module obue_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  obue_pkg::req_type req_item,
   output obue_pkg::work_type work_item
);

   logic        have_previous_ff, have_previous_in;
   logic [31:0] previous_seq_ff, previous_seq_in;
   logic [31:0] gap_counter_ff, gap_counter_in;
   logic [31:0] packet_counter_ff, packet_counter_in;
   logic        gap;

   // Sequence check and counter update for the incoming item.
   always_comb begin
      gap               = have_previous_ff && (req_item.seq_number != previous_seq_ff + 32'd1);
      have_previous_in  = have_previous_ff;
      previous_seq_in   = previous_seq_ff;
      gap_counter_in    = gap_counter_ff;
      packet_counter_in = packet_counter_ff;
      if (accept && !req_item.short_frame) begin
         have_previous_in  = 1'b1;
         previous_seq_in   = req_item.seq_number;
         gap_counter_in    = gap_counter_ff + (gap ? 32'd1 : 32'd0);
         packet_counter_in = packet_counter_ff + 32'd1;
      end
   end

   // The queued item carries the counters as they stand after this item.
   always_comb begin
      work_item.short_frame  = req_item.short_frame;
      work_item.kind         = req_item.kind;
      work_item.gaps_seen    = gap_counter_in;
      work_item.packets_seen = packet_counter_in;
      work_item.order_key    = req_item.order_key;
      work_item.px           = req_item.px;
      work_item.qty          = req_item.qty;
      if (req_item.short_frame) begin
         work_item.status = obue_pkg::STATUS_SHORT;
      end else if (gap) begin
         work_item.status = obue_pkg::STATUS_GAP;
      end else begin
         work_item.status = obue_pkg::STATUS_IN_SEQ;
      end
   end

   // Sequence tracking registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         have_previous_ff  <= 1'b0;
         previous_seq_ff   <= 32'd0;
         gap_counter_ff    <= 32'd0;
         packet_counter_ff <= 32'd0;
      end else begin
         have_previous_ff  <= have_previous_in;
         previous_seq_ff   <= previous_seq_in;
         gap_counter_ff    <= gap_counter_in;
         packet_counter_ff <= packet_counter_in;
      end
   end

endmodule

// File: hdl/obue_queue.sv
// ----------------------------------------------------------------------------
// Order book update engine queue
// Short register queue that decouples the front end from the table stage.
// ----------------------------------------------------------------------------
module obue_queue #(
   parameter int DEPTH = obue_pkg::OBUE_QUEUE_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  obue_pkg::work_type     push_item,
   input  logic                   pop,
   output obue_pkg::work_type     head_item,
   output obue_pkg::q_status_type q_status
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   obue_pkg::work_type entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   // Pointer and fill count update; pointers wrap at the last entry.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   assign head_item      = entries_ff[rd_ptr_ff];
   assign q_status.full  = (count_ff == CNT_W'(DEPTH));
   assign q_status.empty = (count_ff == '0);

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Item storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// File: hdl/obue_back.sv
// ----------------------------------------------------------------------------
// Order book update engine table stage
// Clears the order table after reset, then reads, updates and writes back
// one slot per item and presents the result for one cycle.
// ----------------------------------------------------------------------------
module obue_back #(
   parameter int SLOTS      = obue_pkg::OBUE_SLOTS,
   parameter int EPOCH_BITS = obue_pkg::OBUE_EPOCH_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  obue_pkg::work_type     head_item,
   input  obue_pkg::q_status_type q_status,
   output logic                   pop,
   output logic                   clearing,
   output logic                   rsp_strobe,
   output obue_pkg::rsp_type      rsp_item
);

   localparam int IDX_W = $clog2(SLOTS);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC
   } state_type;

   typedef struct packed {
      logic [63:0]           key;
      logic [EPOCH_BITS-1:0] epoch;
      logic                  live;
      logic [31:0]           px;
      logic [31:0]           qty;
   } entry_type;

   entry_type table_mem [SLOTS];

   state_type             state_ff;
   logic [IDX_W-1:0]      clr_addr_ff;
   logic [EPOCH_BITS-1:0] epoch_ff, epoch_in;
   obue_pkg::work_type    work_ff;
   entry_type             rd_data_ff;
   entry_type             entry_in;
   logic                  rsp_strobe_ff;
   obue_pkg::rsp_type     rsp_ff, rsp_in;
   logic                  hit;
   logic                  upd_write;
   logic                  matched;
   logic                  trade;
   logic                  mem_we;
   logic [IDX_W-1:0]      mem_waddr;
   entry_type             mem_wdata;

   assign pop        = (state_ff == ST_IDLE) && !q_status.empty;
   assign clearing   = (state_ff == ST_CLEAR);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

   // Apply the queued update to the slot that was read in the previous cycle.
   always_comb begin
      hit       = (rd_data_ff.epoch == epoch_ff) && (rd_data_ff.key == work_ff.order_key);
      entry_in  = rd_data_ff;
      upd_write = 1'b0;
      matched   = 1'b0;
      trade     = 1'b0;
      epoch_in  = epoch_ff;
      if (!work_ff.short_frame) begin
         unique case (work_ff.kind)
            obue_pkg::KIND_ADD: begin
               entry_in.key   = work_ff.order_key;
               entry_in.epoch = epoch_ff;
               entry_in.live  = 1'b1;
               entry_in.px    = work_ff.px;
               entry_in.qty   = work_ff.qty;
               upd_write      = 1'b1;
            end
            obue_pkg::KIND_CANCEL: begin
               if (hit) begin
                  entry_in.live = 1'b0;
                  upd_write     = 1'b1;
                  matched       = 1'b1;
               end
            end
            obue_pkg::KIND_MODIFY: begin
               if (hit) begin
                  entry_in.px  = work_ff.px;
                  entry_in.qty = work_ff.qty;
                  upd_write    = 1'b1;
                  matched      = 1'b1;
               end
            end
            obue_pkg::KIND_TRADE: begin
               trade = 1'b1;
            end
            obue_pkg::KIND_CLEAR: begin
               epoch_in = epoch_ff + EPOCH_BITS'(1);
            end
            default: begin
            end
         endcase
      end
   end

   // Result fields; a short frame reports no slot.
   always_comb begin
      rsp_in.status       = work_ff.status;
      rsp_in.gaps_seen    = work_ff.gaps_seen;
      rsp_in.packets_seen = work_ff.packets_seen;
      rsp_in.matched      = matched;
      rsp_in.trade_seen   = trade;
      rsp_in.epoch_now    = 16'(epoch_in);
      if (work_ff.short_frame) begin
         rsp_in.slot_active   = 1'b0;
         rsp_in.slot_price    = 32'd0;
         rsp_in.slot_quantity = 32'd0;
      end else begin
         rsp_in.slot_active   = entry_in.live;
         rsp_in.slot_price    = entry_in.px;
         rsp_in.slot_quantity = entry_in.qty;
      end
   end

   // Table write port: zeros during the clearing pass, else the updated slot.
   always_comb begin
      if (state_ff == ST_CLEAR) begin
         mem_we    = 1'b1;
         mem_waddr = clr_addr_ff;
         mem_wdata = '0;
      end else begin
         mem_we    = (state_ff == ST_EXEC) && upd_write;
         mem_waddr = work_ff.order_key[IDX_W-1:0];
         mem_wdata = entry_in;
      end
   end

   // Order table with one write port and one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         table_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= table_mem[head_item.order_key[IDX_W-1:0]];
   end

   // Sequencer: clearing pass, then read and update one item at a time.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_addr_ff   <= '0;
         epoch_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         unique case (state_ff)
            ST_CLEAR: begin
               clr_addr_ff <= clr_addr_ff + IDX_W'(1);
               if (clr_addr_ff == IDX_W'(SLOTS - 1)) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (!q_status.empty) begin
                  work_ff  <= head_item;
                  state_ff <= ST_EXEC;
               end
            end
            ST_EXEC: begin
               epoch_ff      <= epoch_in;
               rsp_ff        <= rsp_in;
               rsp_strobe_ff <= 1'b1;
               state_ff      <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule
